FILE: rtl/aes128_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package aes128_pkg;

  // round key storage: one row of 128 bits per round key
  localparam int KEY_ROWS = 11;
  localparam int KEY_AW   = $clog2(KEY_ROWS);
  localparam int BLK_W    = 128;

  localparam logic [KEY_AW-1:0] LAST_ROUND = KEY_AW'(KEY_ROWS - 1);

  // reduction constant of the field polynomial x^8 + x^4 + x^3 + x + 1
  localparam logic [7:0] GF_POLY = 8'h1B;

  typedef logic [BLK_W-1:0]  block_t;
  typedef logic [KEY_AW-1:0] key_addr_t;

  typedef enum logic {
    CMD_LOAD_KEY = 1'b0,
    CMD_ENCRYPT  = 1'b1
  } cmd_t;

  // round control: first is the bare key add, last skips mix columns
  typedef struct packed {
    logic first;
    logic last;
  } rnd_ctrl_t;

  localparam logic [7:0] SBOX_TABLE [256] = '{
    8'h63, 8'h7c, 8'h77, 8'h7b, 8'hf2, 8'h6b, 8'h6f, 8'hc5,
    8'h30, 8'h01, 8'h67, 8'h2b, 8'hfe, 8'hd7, 8'hab, 8'h76,
    8'hca, 8'h82, 8'hc9, 8'h7d, 8'hfa, 8'h59, 8'h47, 8'hf0,
    8'had, 8'hd4, 8'ha2, 8'haf, 8'h9c, 8'ha4, 8'h72, 8'hc0,
    8'hb7, 8'hfd, 8'h93, 8'h26, 8'h36, 8'h3f, 8'hf7, 8'hcc,
    8'h34, 8'ha5, 8'he5, 8'hf1, 8'h71, 8'hd8, 8'h31, 8'h15,
    8'h04, 8'hc7, 8'h23, 8'hc3, 8'h18, 8'h96, 8'h05, 8'h9a,
    8'h07, 8'h12, 8'h80, 8'he2, 8'heb, 8'h27, 8'hb2, 8'h75,
    8'h09, 8'h83, 8'h2c, 8'h1a, 8'h1b, 8'h6e, 8'h5a, 8'ha0,
    8'h52, 8'h3b, 8'hd6, 8'hb3, 8'h29, 8'he3, 8'h2f, 8'h84,
    8'h53, 8'hd1, 8'h00, 8'hed, 8'h20, 8'hfc, 8'hb1, 8'h5b,
    8'h6a, 8'hcb, 8'hbe, 8'h39, 8'h4a, 8'h4c, 8'h58, 8'hcf,
    8'hd0, 8'hef, 8'haa, 8'hfb, 8'h43, 8'h4d, 8'h33, 8'h85,
    8'h45, 8'hf9, 8'h02, 8'h7f, 8'h50, 8'h3c, 8'h9f, 8'ha8,
    8'h51, 8'ha3, 8'h40, 8'h8f, 8'h92, 8'h9d, 8'h38, 8'hf5,
    8'hbc, 8'hb6, 8'hda, 8'h21, 8'h10, 8'hff, 8'hf3, 8'hd2,
    8'hcd, 8'h0c, 8'h13, 8'hec, 8'h5f, 8'h97, 8'h44, 8'h17,
    8'hc4, 8'ha7, 8'h7e, 8'h3d, 8'h64, 8'h5d, 8'h19, 8'h73,
    8'h60, 8'h81, 8'h4f, 8'hdc, 8'h22, 8'h2a, 8'h90, 8'h88,
    8'h46, 8'hee, 8'hb8, 8'h14, 8'hde, 8'h5e, 8'h0b, 8'hdb,
    8'he0, 8'h32, 8'h3a, 8'h0a, 8'h49, 8'h06, 8'h24, 8'h5c,
    8'hc2, 8'hd3, 8'hac, 8'h62, 8'h91, 8'h95, 8'he4, 8'h79,
    8'he7, 8'hc8, 8'h37, 8'h6d, 8'h8d, 8'hd5, 8'h4e, 8'ha9,
    8'h6c, 8'h56, 8'hf4, 8'hea, 8'h65, 8'h7a, 8'hae, 8'h08,
    8'hba, 8'h78, 8'h25, 8'h2e, 8'h1c, 8'ha6, 8'hb4, 8'hc6,
    8'he8, 8'hdd, 8'h74, 8'h1f, 8'h4b, 8'hbd, 8'h8b, 8'h8a,
    8'h70, 8'h3e, 8'hb5, 8'h66, 8'h48, 8'h03, 8'hf6, 8'h0e,
    8'h61, 8'h35, 8'h57, 8'hb9, 8'h86, 8'hc1, 8'h1d, 8'h9e,
    8'he1, 8'hf8, 8'h98, 8'h11, 8'h69, 8'hd9, 8'h8e, 8'h94,
    8'h9b, 8'h1e, 8'h87, 8'he9, 8'hce, 8'h55, 8'h28, 8'hdf,
    8'h8c, 8'ha1, 8'h89, 8'h0d, 8'hbf, 8'he6, 8'h42, 8'h68,
    8'h41, 8'h99, 8'h2d, 8'h0f, 8'hb0, 8'h54, 8'hbb, 8'h16
  };

  // multiply by x in the field
  function automatic logic [7:0] gf_dbl(input logic [7:0] a);
    return {a[6:0], 1'b0} ^ (a[7] ? GF_POLY : 8'h00);
  endfunction

  // one column, row 0 in the top byte
  function automatic logic [31:0] mix_col(input logic [31:0] col);
    logic [7:0] a0, a1, a2, a3, d0, d1, d2, d3;
    a0 = col[31:24];
    a1 = col[23:16];
    a2 = col[15:8];
    a3 = col[7:0];
    d0 = gf_dbl(a0);
    d1 = gf_dbl(a1);
    d2 = gf_dbl(a2);
    d3 = gf_dbl(a3);
    return {d0 ^ d1 ^ a1 ^ a2 ^ a3,
            a0 ^ d1 ^ d2 ^ a2 ^ a3,
            a0 ^ a1 ^ d2 ^ d3 ^ a3,
            d0 ^ a0 ^ a1 ^ a2 ^ d3};
  endfunction

endpackage

`default_nettype wire

FILE: rtl/aes128_key_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module aes128_key_ram import aes128_pkg::*; (
  input  logic      clk,
  input  logic      wr_en,
  input  key_addr_t wr_addr,
  input  block_t    wr_data,
  input  key_addr_t rd_addr,
  output block_t    rd_data
);

  // one 128-bit row per round key, high half in the upper bits
  block_t mem [KEY_ROWS];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule

`default_nettype wire

FILE: rtl/aes128_round.sv
`timescale 1ns / 1ps
`default_nettype none

module aes128_round import aes128_pkg::*; (
  input  block_t    blk_in,
  input  block_t    rkey,
  input  rnd_ctrl_t ctrl,
  output block_t    blk_out
);

  block_t ss;
  block_t mixed;

  // sub bytes and shift rows; byte 4*c+r sits at bits 127-8*(4*c+r)
  always_comb begin
    ss = '0;
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        ss[127 - 8 * (4 * c + r) -: 8] =
          SBOX_TABLE[blk_in[127 - 8 * (4 * ((c + r) & 3) + r) -: 8]];
      end
    end
  end

  always_comb begin
    mixed = '0;
    for (int c = 0; c < 4; c++) begin
      mixed[127 - 32 * c -: 32] = mix_col(ss[127 - 32 * c -: 32]);
    end
  end

  assign blk_out = (ctrl.first ? blk_in : (ctrl.last ? ss : mixed)) ^ rkey;

endmodule

`default_nettype wire

FILE: rtl/aes128_block_encrypt.sv
`timescale 1ns / 1ps
`default_nettype none

// aes-128 block encryption with externally supplied round keys
//
// input channel: in_tuser carries cmd; load key (cmd 0) writes round key
//   round_index (0..10) into the key memory and returns nothing, an index
//   of 11..15 is dropped; encrypt (cmd 1) takes a 128-bit plaintext
// output channel: one transaction per encrypt carrying the ciphertext
// rounds: one round per cycle through the shared round unit, the last round
//   holding until the output register frees; each round's key is read from
//   the key memory in the cycle before that round
// acceptance: a new transaction is taken on the cycle the current result
//   moves to the output register, and at any time while the round unit is idle
// stalls: the finished result waits in the output register; a second block
//   may run meanwhile and holds in its last round until the register frees
// reset: clears control and the output valid; the key memory keeps no reset
//   value, so all eleven keys must be loaded before the first encrypt
module aes128_block_encrypt import aes128_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [135:0] in_tdata,   // round_index[3:0], data_hi[67:4], data_lo[131:68], pad
  input  logic [0:0]   in_tuser,   // cmd[0]
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [127:0] out_tdata   // cipher_hi[63:0], cipher_lo[127:64]
);

  typedef enum logic {
    ST_IDLE,
    ST_RUN
  } fsm_t;

  fsm_t      fsm_r;
  key_addr_t round_r;     // key index currently on the memory read port
  block_t    blk_r;       // working state
  logic      out_valid_r;
  block_t    out_data_r;

  // input transaction fields
  logic        in_cmd;
  logic [3:0]  in_idx;
  logic [63:0] in_hi;
  logic [63:0] in_lo;

  logic      in_hs;
  logic      out_hs;
  logic      last_step;
  logic      finish;
  logic      start;
  logic      key_wr;
  key_addr_t rd_addr;
  block_t    rd_key;
  block_t    round_out;
  rnd_ctrl_t ctrl;

  assign in_cmd = in_tuser[0];
  assign in_idx = in_tdata[3:0];
  assign in_hi  = in_tdata[67:4];
  assign in_lo  = in_tdata[131:68];

  // the last round can only retire once the output register is free
  assign last_step = (fsm_r == ST_RUN) && (round_r == LAST_ROUND);
  assign finish    = last_step && (!out_valid_r || out_tready);
  assign in_tready = (fsm_r == ST_IDLE) || finish;

  assign in_hs  = in_tvalid && in_tready;
  assign out_hs = out_valid_r && out_tready;
  assign start  = in_hs && (in_cmd == CMD_ENCRYPT);
  assign key_wr = in_hs && (in_cmd == CMD_LOAD_KEY) && (in_idx < 4'(KEY_ROWS));

  // fetch one key ahead: key 0 on start, then the next round's key;
  // the last key stays on the port while the result is held back
  always_comb begin
    if (start) begin
      rd_addr = '0;
    end else if (fsm_r == ST_RUN && round_r != LAST_ROUND) begin
      rd_addr = KEY_AW'(round_r + 1'b1);
    end else if (fsm_r == ST_RUN) begin
      rd_addr = LAST_ROUND;
    end else begin
      rd_addr = '0;
    end
  end

  assign ctrl.first = (round_r == '0);
  assign ctrl.last  = (round_r == LAST_ROUND);

  aes128_key_ram u_key_ram (
    .clk     (clk),
    .wr_en   (key_wr),
    .wr_addr (KEY_AW'(in_idx)),
    .wr_data ({in_hi, in_lo}),
    .rd_addr (rd_addr),
    .rd_data (rd_key)
  );

  aes128_round u_round (
    .blk_in  (blk_r),
    .rkey    (rd_key),
    .ctrl    (ctrl),
    .blk_out (round_out)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fsm_r       <= ST_IDLE;
      round_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      // a new result may load the register on the edge the old one leaves
      if (finish) begin
        out_valid_r <= 1'b1;
        out_data_r  <= round_out;
      end else if (out_hs) begin
        out_valid_r <= 1'b0;
      end
      // a new block may enter on the same edge the previous one retires
      if (start) begin
        fsm_r   <= ST_RUN;
        round_r <= '0;
        blk_r   <= {in_hi, in_lo};
      end else if (finish) begin
        fsm_r   <= ST_IDLE;
        round_r <= '0;
      end else if (fsm_r == ST_RUN && !last_step) begin
        blk_r   <= round_out;
        round_r <= KEY_AW'(round_r + 1'b1);
      end
    end
  end

  assign out_tvalid       = out_valid_r;
  assign out_tdata[63:0]  = out_data_r[127:64];
  assign out_tdata[127:64] = out_data_r[63:0];

`ifndef SYNTHESIS
  // an accepted encrypt always starts at round 0
  a_start_round0: assert property (@(posedge clk) disable iff (!rst_n)
    start |=> (fsm_r == ST_RUN) && (round_r == '0))
    else $error("encrypt did not start at round 0");

  // rounds advance by one each cycle until the last one
  a_round_step: assert property (@(posedge clk) disable iff (!rst_n)
    (fsm_r == ST_RUN) && (round_r != LAST_ROUND)
      |=> (fsm_r == ST_RUN) && (round_r == KEY_AW'($past(round_r) + 1'b1)))
    else $error("round counter skipped or stopped");

  // counter never runs past the last key
  a_round_range: assert property (@(posedge clk) disable iff (!rst_n)
    round_r <= LAST_ROUND)
    else $error("round counter out of range");

  // no input taken while a block is mid-way through its rounds
  a_busy_no_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (fsm_r == ST_RUN) && (round_r != LAST_ROUND) |-> !in_tready)
    else $error("input accepted during rounds");

  // a result appears only out of the last round
  a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(last_step))
    else $error("result produced outside the last round");
`endif

endmodule

`default_nettype wire
